@@ hdl/depq_pkg.sv @@
// ----------------------------------------------------------------------------
// depq_pkg
// Types and constants shared by the double-ended priority queue modules.
// ----------------------------------------------------------------------------
package depq_pkg;

	// Transaction modes.
	localparam logic [1:0] MODE_INSERT     = 2'd0;
	localparam logic [1:0] MODE_POP_LARGE  = 2'd1;
	localparam logic [1:0] MODE_POP_SMALL  = 2'd2;
	localparam logic [1:0] MODE_CLEAR      = 2'd3;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;

	// Input transaction.
	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [VALUE_W-1:0]  value;
	} item_t;

	// Result transaction.
	typedef struct packed {
		logic                       is_empty;
		logic                       dropped;
		logic [COUNT_W-1:0]         entry_count;
		logic signed [VALUE_W-1:0]  largest;
		logic signed [VALUE_W-1:0]  smallest;
	} result_t;

	// Command broadcast to every cell of one chain.
	typedef struct packed {
		logic                       ins;        // insert the broadcast value
		logic                       pop_front;  // shift toward cell 0
		logic                       drop_back;  // invalidate the last valid cell
		logic                       clr;        // invalidate all cells
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	// What one cell shows to its neighbors.
	typedef struct packed {
		logic                       valid;
		logic                       ge;         // new value belongs at or before this cell
		logic signed [VALUE_W-1:0]  data;
	} link_t;

endpackage

@@ hdl/depq_cell.sv @@
// ----------------------------------------------------------------------------
// depq_cell
// One slot of a sorted register chain. It holds one value and its valid bit
// and updates from its own contents or those of a neighbor.
// ----------------------------------------------------------------------------
module depq_cell #(
	parameter bit DESCEND = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  depq_pkg::cmd_t   cmd,
	input  depq_pkg::link_t  left,
	input  depq_pkg::link_t  right,
	output depq_pkg::link_t  self
);

	logic                                  valid_q;
	logic signed [depq_pkg::VALUE_W-1:0]   data_q;
	logic                                  ge;

	// The new value is placed in front of the first cell whose entry does not
	// come before it in the chain's order; empty cells always qualify.
	always_comb begin
		if (DESCEND) begin
			ge = !valid_q || (data_q <= cmd.value);
		end else begin
			ge = !valid_q || (data_q >= cmd.value);
		end
	end

	assign self.valid = valid_q;
	assign self.ge    = ge;
	assign self.data  = data_q;

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (left.ge) begin
				valid_q <= left.valid;
			end else if (ge) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.pop_front) begin
			valid_q <= right.valid;
		end else if (cmd.drop_back) begin
			if (valid_q && !right.valid) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Stored value.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left.ge) begin
				data_q <= left.data;
			end else if (ge) begin
				data_q <= cmd.value;
			end
		end else if (cmd.pop_front) begin
			data_q <= right.data;
		end
	end

endmodule

@@ hdl/depq_chain.sv @@
// ----------------------------------------------------------------------------
// depq_chain
// A row of cells kept sorted; cell 0 holds the front entry of the order.
// ----------------------------------------------------------------------------
module depq_chain #(
	parameter int  DEPTH   = 1024,
	parameter bit  DESCEND = 1'b0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  depq_pkg::cmd_t                       cmd,
	output logic                                 front_valid,
	output logic signed [depq_pkg::VALUE_W-1:0]  front_data
);

	depq_pkg::link_t links [DEPTH+2];

	// Boundary links: nothing ahead of cell 0, nothing behind the last cell.
	assign links[0]       = '0;
	assign links[DEPTH+1] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		depq_cell #(
			.DESCEND (DESCEND)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (links[i]),
			.right  (links[i+2]),
			.self   (links[i+1])
		);
	end

	assign front_valid = links[1].valid;
	assign front_data  = links[1].data;

endmodule

@@ hdl/double_ended_priority_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// The result of a transaction is registered and shown in the cycle after it is taken.
// Throughput: one transaction per cycle; busy stays low, every cell of the
// two chains updates in the same cycle.
// Reset clears the count and all valid bits; a transaction can be taken
// as soon as reset is released.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  depq_pkg::item_t    item,
	output logic               done,
	output depq_pkg::result_t  result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]                         count_q;
	logic                                  done_q;
	logic                                  dropped_q;
	logic                                  accept;
	logic                                  nonempty;
	logic                                  full;
	depq_pkg::cmd_t                        cmd_asc;
	depq_pkg::cmd_t                        cmd_desc;
	logic                                  small_valid;
	logic                                  large_valid;
	logic signed [depq_pkg::VALUE_W-1:0]   small_data;
	logic signed [depq_pkg::VALUE_W-1:0]   large_data;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign nonempty = (count_q != '0);
	assign full     = (count_q == CW'(CAPACITY));

	// Decode the transaction into commands for both chains. The ascending
	// chain keeps the smallest entry at its front, the descending chain the
	// largest; removing at one end shifts one chain and trims the other.
	always_comb begin
		cmd_asc  = '0;
		cmd_desc = '0;
		cmd_asc.value  = item.value;
		cmd_desc.value = item.value;
		if (accept) begin
			unique case (item.mode)
				depq_pkg::MODE_INSERT: begin
					cmd_asc.ins  = !full;
					cmd_desc.ins = !full;
				end
				depq_pkg::MODE_POP_LARGE: begin
					cmd_desc.pop_front = nonempty;
					cmd_asc.drop_back  = nonempty;
				end
				depq_pkg::MODE_POP_SMALL: begin
					cmd_asc.pop_front  = nonempty;
					cmd_desc.drop_back = nonempty;
				end
				depq_pkg::MODE_CLEAR: begin
					cmd_asc.clr  = 1'b1;
					cmd_desc.clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	depq_chain #(
		.DEPTH   (CAPACITY),
		.DESCEND (1'b0)
	) u_asc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_asc),
		.front_valid (small_valid),
		.front_data  (small_data)
	);

	depq_chain #(
		.DEPTH   (CAPACITY),
		.DESCEND (1'b1)
	) u_desc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_desc),
		.front_valid (large_valid),
		.front_data  (large_data)
	);

	// Entry count, result strobe and refused-insert flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			done_q    <= accept;
			dropped_q <= 1'b0;
			if (accept) begin
				unique case (item.mode) inside
					depq_pkg::MODE_INSERT: begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					depq_pkg::MODE_POP_LARGE, depq_pkg::MODE_POP_SMALL: begin
						if (nonempty) begin
							count_q <= count_q - CW'(1);
						end
					end
					depq_pkg::MODE_CLEAR: begin
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result fields come straight from the registered state.
	assign done                = done_q;
	assign result.is_empty     = !nonempty;
	assign result.dropped      = dropped_q;
	assign result.entry_count  = depq_pkg::COUNT_W'(count_q);
	assign result.largest      = large_valid ? large_data : '0;
	assign result.smallest     = small_valid ? small_data : '0;

endmodule

@@ hdl/depq_checker.sv @@
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks on the double-ended priority queue.
// ----------------------------------------------------------------------------
module depq_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  depq_pkg::item_t    item,
	input  logic               done,
	input  depq_pkg::result_t  result
);

	// Every accepted transaction gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (done == $past(start && !busy)))
		else $error("result strobe does not follow the accepted transaction");

	// A held store reports its bounds in order.
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_empty) |-> (result.largest >= result.smallest))
		else $error("largest entry below smallest entry");

	// An empty store reports zero count and zero bounds.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
		(result.entry_count == '0 && result.largest == '0 && result.smallest == '0))
		else $error("empty store reports nonzero fields");

	// Only a refused insert is flagged, and the store is then not empty.
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dropped) |->
		($past(item.mode) == depq_pkg::MODE_INSERT && !result.is_empty))
		else $error("dropped flag on a transaction that is not a refused insert");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

@@ dv/tb_double_ended_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_priority_queue
// Drives insert, remove and clear transactions into the sorted store and
// checks every result against a queue-based model of the store. A short
// table of directed transactions covers the extremes and the corner cases.
// Random traffic then fills the store to capacity, overflows it, drains it
// and mixes all modes. Random gaps and back-to-back bursts fall between
// transactions.
// ----------------------------------------------------------------------------
module tb_double_ended_priority_queue;

	localparam int DEPTH        = 1024;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1950;

	localparam logic signed [depq_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
	localparam logic signed [depq_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;

	localparam depq_pkg::result_t EMPTY_RESULT = '{1'b1, 1'b0, 11'd0, 32'sd0, 32'sd0};

	// One row of the directed table: a transaction and, where it is obvious,
	// the result typed in by hand.
	typedef struct {
		depq_pkg::item_t   stim;
		bit                typed;
		depq_pkg::result_t want;
	} stim_row_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              busy;
	depq_pkg::item_t   item   = '0;
	logic              done;
	depq_pkg::result_t result;

	// Model of the store contents, ascending from index 0.
	logic signed [depq_pkg::VALUE_W-1:0] held_values [$];
	// Results owed by the block, oldest first.
	depq_pkg::result_t pending_results [$];
	depq_pkg::result_t oldest_result;

	int error_count = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int random_sent = 0;

	stim_row_t directed_rows [23];

	always #10 clk = ~clk;

	double_ended_priority_queue #(
		.CAPACITY(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// Applies one transaction to the model store and returns the result it causes.
	function automatic depq_pkg::result_t predict_store_result(input depq_pkg::item_t it);
		depq_pkg::result_t r;
		int pos;
		r = '0;
		case (it.mode)
			depq_pkg::MODE_INSERT: begin
				if (held_values.size() >= DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					// Equal values go in front of existing ones.
					pos = 0;
					while (pos < held_values.size() &&
					       $signed(held_values[pos]) < $signed(it.value)) begin
						pos++;
					end
					held_values.insert(pos, it.value);
				end
			end
			depq_pkg::MODE_POP_LARGE: begin
				if (held_values.size() > 0) begin
					void'(held_values.pop_back());
				end
			end
			depq_pkg::MODE_POP_SMALL: begin
				if (held_values.size() > 0) begin
					void'(held_values.pop_front());
				end
			end
			default: begin
				held_values.delete();
			end
		endcase
		r.is_empty    = (held_values.size() == 0);
		r.entry_count = depq_pkg::COUNT_W'(held_values.size());
		if (held_values.size() > 0) begin
			r.largest  = held_values[held_values.size()-1];
			r.smallest = held_values[0];
		end
		return r;
	endfunction

	// Presents one transaction after a random gap and records its result once taken.
	task automatic send_item(input depq_pkg::item_t it, input depq_pkg::result_t want);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(20, 60);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 19);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(want);
	endtask

	// Draws a random transaction with the given mode mix and sends it.
	task automatic send_random(input int insert_pct, input int clear_permille);
		depq_pkg::item_t it;
		int pick;
		it.value = $urandom;
		pick = $urandom_range(0, 9);
		// Bias values toward small magnitudes, extremes and duplicates.
		case (pick)
			5, 6: begin
				it.value = depq_pkg::VALUE_W'(int'($urandom_range(0, 16)) - 8);
			end
			7: begin
				it.value = ($urandom_range(0, 1) != 0) ? MAX_VALUE : MIN_VALUE;
			end
			8: begin
				if (held_values.size() > 0) begin
					it.value = held_values[$urandom_range(0, held_values.size()-1)];
				end
			end
			default: begin
			end
		endcase
		if ($urandom_range(0, 999) < clear_permille) begin
			it.mode = depq_pkg::MODE_CLEAR;
		end else if ($urandom_range(0, 99) < insert_pct) begin
			it.mode = depq_pkg::MODE_INSERT;
		end else if ($urandom_range(0, 1) == 0) begin
			it.mode = depq_pkg::MODE_POP_LARGE;
		end else begin
			it.mode = depq_pkg::MODE_POP_SMALL;
		end
		send_item(it, predict_store_result(it));
		random_sent++;
	endtask

	task automatic check_field(input string field,
	                           input logic [depq_pkg::VALUE_W-1:0] want_v,
	                           input logic [depq_pkg::VALUE_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
			         $time, field, want_v, got_v);
			error_count++;
		end
	endtask

	// Compare every result transaction with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual %p",
				         $time, result);
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("is_empty", depq_pkg::VALUE_W'(oldest_result.is_empty),
				            depq_pkg::VALUE_W'(result.is_empty));
				check_field("dropped", depq_pkg::VALUE_W'(oldest_result.dropped),
				            depq_pkg::VALUE_W'(result.dropped));
				check_field("entry_count", depq_pkg::VALUE_W'(oldest_result.entry_count),
				            depq_pkg::VALUE_W'(result.entry_count));
				check_field("largest", oldest_result.largest, result.largest);
				check_field("smallest", oldest_result.smallest, result.smallest);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		depq_pkg::item_t   it;
		depq_pkg::result_t want;
		int                insert_pct;

		directed_rows = '{
			'{'{depq_pkg::MODE_POP_LARGE, 32'sd0},      1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_POP_SMALL, MAX_VALUE},   1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_CLEAR, 32'sd0},          1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_INSERT, MAX_VALUE},      1'b1,
			  '{1'b0, 1'b0, 11'd1, MAX_VALUE, MAX_VALUE}},
			'{'{depq_pkg::MODE_INSERT, MIN_VALUE},      1'b1,
			  '{1'b0, 1'b0, 11'd2, MAX_VALUE, MIN_VALUE}},
			'{'{depq_pkg::MODE_INSERT, 32'sd0},         1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, -32'sd1},        1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, 32'sd1},         1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, 32'sd0},         1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, MAX_VALUE},      1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, MIN_VALUE},      1'b0, '0},
			'{'{depq_pkg::MODE_POP_LARGE, 32'sd0},      1'b0, '0},
			'{'{depq_pkg::MODE_POP_SMALL, 32'sd0},      1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, 32'sh5555_5555}, 1'b0, '0},
			'{'{depq_pkg::MODE_INSERT, 32'shAAAA_AAAA}, 1'b0, '0},
			'{'{depq_pkg::MODE_POP_LARGE, MIN_VALUE},   1'b0, '0},
			'{'{depq_pkg::MODE_POP_SMALL, MAX_VALUE},   1'b0, '0},
			'{'{depq_pkg::MODE_CLEAR, -32'sd1},         1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_INSERT, -32'sd5},        1'b1,
			  '{1'b0, 1'b0, 11'd1, -32'sd5, -32'sd5}},
			'{'{depq_pkg::MODE_POP_SMALL, 32'sd0},      1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_INSERT, 32'sd42},        1'b1,
			  '{1'b0, 1'b0, 11'd1, 32'sd42, 32'sd42}},
			'{'{depq_pkg::MODE_POP_LARGE, 32'sd7},      1'b1, EMPTY_RESULT},
			'{'{depq_pkg::MODE_POP_SMALL, -32'sd1},     1'b1, EMPTY_RESULT}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table; the model still tracks typed rows to stay in step.
		foreach (directed_rows[i]) begin
			want = predict_store_result(directed_rows[i].stim);
			if (directed_rows[i].typed) begin
				want = directed_rows[i].want;
			end
			send_item(directed_rows[i].stim, want);
		end

		// Fill the store to capacity, then push inserts that must be dropped.
		while (held_values.size() < DEPTH) send_random(95, 0);
		repeat (8) send_random(100, 0);

		// Remove from both ends of a full store, with some inserts mixed in, then clear it.
		repeat (120) send_random(20, 0);
		it.mode  = depq_pkg::MODE_CLEAR;
		it.value = $urandom;
		send_item(it, predict_store_result(it));

		// Mixed traffic in stretches with differing insert rates.
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: insert_pct = 15;
				1: insert_pct = 50;
				default: insert_pct = 85;
			endcase
			repeat (40) send_random(insert_pct, 5);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/depq_pkg.sv
hdl/depq_cell.sv
hdl/depq_chain.sv
hdl/double_ended_priority_queue.sv
hdl/depq_checker.sv
dv/tb_double_ended_priority_queue.sv
